>>> rtl/core/wifi_station_tracker_macros.svh
// ----------------------------------------------------------------------------
// wifi_station_tracker_macros
// Assertion macros for the station tracker. Clocked on aclk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef WIFI_STATION_TRACKER_MACROS_SVH
`define WIFI_STATION_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF

`define WST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("station tracker check failed");

`define WST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("station tracker check failed");

`define WST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("station tracker check failed");

`else

`define WST_ASSERT(lbl, prop)

`define WST_ASSERT_IMP(lbl, ante, cons)

`define WST_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/wst_pkg.sv
// ----------------------------------------------------------------------------
// wst_pkg
// Shared constants, codes and control structs of the station tracker.
// ----------------------------------------------------------------------------
package wst_pkg;

    localparam int MAX_STATIONS_DEF = 32;

    localparam int ADDR_W     = 48;
    localparam int LEN_W      = 12;
    localparam int FC_W       = 16;
    localparam int RSSI_W     = 8;
    localparam int OUTCOME_W  = 3;
    localparam int ENTRY_W    = 5;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(24);
    localparam logic [1:0]       FTYPE_DATA    = 2'd2;
    localparam int               FC_TYPE_LO    = 2;
    localparam int               FC_TO_DS      = 8;
    localparam int               FC_FROM_DS    = 9;
    localparam int               GROUP_BIT     = 40;

    // x/10 for 0 <= x <= 1280: (x * 6554) >> 16
    localparam int               SUM_W       = 12;
    localparam int               MAG_W       = 11;
    localparam int               RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] DIV10_MUL = RECIP_W'(6554);
    localparam int               DIV10_SHIFT = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLE = 2'd0,
        CFG_FILTER_BSSID  = 2'd1
    } cfg_index_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_IGNORED    = 3'd0,
        OUT_FILTERED   = 3'd1,
        OUT_BAD_STA    = 3'd2,
        OUT_STA_IS_AP  = 3'd3,
        OUT_UPDATED    = 3'd4,
        OUT_INSERTED   = 3'd5,
        OUT_TABLE_FULL = 3'd6
    } outcome_t;

    // search token flags passed cell to cell
    typedef struct packed {
        logic valid;
        logic found;
    } tok_flags_t;

    // broadcast table write control
    typedef struct packed {
        logic en;
        logic mac_en;
    } wr_ctl_t;

endpackage

>>> rtl/core/wst_cell.sv
// ----------------------------------------------------------------------------
// wst_cell
// One table entry. Compares the probe address as the search token passes
// and hands the token to the next cell through a register.
// ----------------------------------------------------------------------------
module wst_cell #(
    parameter int IDX_W = 5,
    parameter int CNT_W = 6,
    parameter int INDEX = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [CNT_W-1:0]                  held,
    input  logic [wst_pkg::ADDR_W-1:0]        probe_mac,
    input  wst_pkg::tok_flags_t               tok_i,
    input  logic [IDX_W-1:0]                  tok_idx_i,
    input  logic signed [wst_pkg::RSSI_W-1:0] tok_str_i,
    output wst_pkg::tok_flags_t               tok_o,
    output logic [IDX_W-1:0]                  tok_idx_o,
    output logic signed [wst_pkg::RSSI_W-1:0] tok_str_o,
    input  wst_pkg::wr_ctl_t                  wr,
    input  logic [IDX_W-1:0]                  wr_idx,
    input  logic [wst_pkg::ADDR_W-1:0]        wr_mac,
    input  logic signed [wst_pkg::RSSI_W-1:0] wr_str
);
    import wst_pkg::*;

    logic [ADDR_W-1:0]        mac_reg;
    logic signed [RSSI_W-1:0] str_reg;
    tok_flags_t               tok_reg;
    logic [IDX_W-1:0]         tok_idx_reg;
    logic signed [RSSI_W-1:0] tok_str_reg;
    logic                     hit;

    assign hit = tok_i.valid && !tok_i.found && (CNT_W'(INDEX) < held)
                 && (mac_reg == probe_mac);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg.valid <= tok_i.valid;
            tok_reg.found <= tok_i.found | hit;
        end
    end

    always_ff @(posedge aclk) begin
        tok_idx_reg <= hit ? IDX_W'(INDEX) : tok_idx_i;
        tok_str_reg <= hit ? str_reg : tok_str_i;
    end

    always_ff @(posedge aclk) begin
        if (wr.en && (wr_idx == IDX_W'(INDEX))) begin
            if (wr.mac_en) begin
                mac_reg <= wr_mac;
            end
            str_reg <= wr_str;
        end
    end

    assign tok_o     = tok_reg;
    assign tok_idx_o = tok_idx_reg;
    assign tok_str_o = tok_str_reg;

endmodule

>>> rtl/core/wifi_station_tracker.sv
// ----------------------------------------------------------------------------
// wifi_station_tracker
// Station discovery table for received 802.11 data frames.
//
//   channel   prefix  handshake                 payload
//   frame     s_      s_valid / s_ready         frame fields, RSSI
//   result    m_      m_valid / m_ready         outcome, entry, station, RSSI
//   config    cfg_    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A frame that stops before the table goes from ST_CLASS straight to ST_DONE.
// A table search walks the token down MAX_STATIONS cells, one per cycle; an
// insert or full table then goes to ST_DONE, an update through ST_SUM, ST_DIV.
// s_ready returns with the result, so the next frame waits for this one's result.
// The table count clears at reset; entries need no clearing pass.
// A stalled result is held in the output register while the next frame is taken.
// ----------------------------------------------------------------------------
`include "wifi_station_tracker_macros.svh"

module wifi_station_tracker #(
    parameter int MAX_STATIONS = wst_pkg::MAX_STATIONS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_is_data_packet,
    input  logic [wst_pkg::LEN_W-1:0]             s_frame_length,
    input  logic [wst_pkg::FC_W-1:0]              s_frame_control,
    input  logic [wst_pkg::ADDR_W-1:0]            s_address_one,
    input  logic [wst_pkg::ADDR_W-1:0]            s_address_two,
    input  logic [wst_pkg::ADDR_W-1:0]            s_address_three,
    input  logic signed [wst_pkg::RSSI_W-1:0]     s_signal_strength,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [wst_pkg::OUTCOME_W-1:0]         m_outcome,
    output logic [wst_pkg::ENTRY_W-1:0]           m_entry_index,
    output logic [wst_pkg::ADDR_W-1:0]            m_station_address,
    output logic signed [wst_pkg::RSSI_W-1:0]     m_smoothed_strength,
    output logic                                  m_table_changed,
    output logic [wst_pkg::COUNT_W-1:0]           m_station_count,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wst_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wst_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import wst_pkg::*;

    localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CNT_W = $clog2(MAX_STATIONS + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLASS = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic              filt_en_reg;
    logic [ADDR_W-1:0] filt_bssid_reg;

    // captured frame
    logic                     is_data_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [FC_W-1:0]          fc_reg;
    logic [ADDR_W-1:0]        a1_reg, a2_reg, a3_reg;
    logic signed [RSSI_W-1:0] rssi_reg;

    // search and arithmetic
    logic [ADDR_W-1:0]        sta_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic signed [RSSI_W-1:0] old_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         held_reg;

    // pending result
    outcome_t                 res_outcome_reg;
    logic [ENTRY_W-1:0]       res_idx_reg;
    logic [ADDR_W-1:0]        res_sta_reg;
    logic signed [RSSI_W-1:0] res_str_reg;
    logic                     res_chg_reg;

    // output register
    logic                     m_valid_reg;
    logic [OUTCOME_W-1:0]     m_outcome_reg;
    logic [ENTRY_W-1:0]       m_idx_reg;
    logic [ADDR_W-1:0]        m_sta_reg;
    logic signed [RSSI_W-1:0] m_str_reg;
    logic                     m_chg_reg;
    logic [COUNT_W-1:0]       m_count_reg;

    // classification
    logic              to_ds, from_ds;
    logic              ignore_frame;
    logic [ADDR_W-1:0] bssid, sta;
    logic              filtered, bad_sta, sta_is_ap, early;
    outcome_t          early_outcome;

    // chain
    tok_flags_t               tok     [MAX_STATIONS+1];
    logic [IDX_W-1:0]         tok_idx [MAX_STATIONS+1];
    logic signed [RSSI_W-1:0] tok_str [MAX_STATIONS+1];
    tok_flags_t               tail;
    wr_ctl_t                  wr;
    logic [IDX_W-1:0]         wr_idx;
    logic signed [RSSI_W-1:0] wr_str;

    // smoothing
    logic signed [SUM_W-1:0]  old_x, rssi_x, sum_calc;
    logic [SUM_W-1:0]         sum_abs;
    logic [MAG_W-1:0]         mag;
    logic [MAG_W+RECIP_W-1:0] prod;
    logic [RSSI_W-1:0]        quot;
    logic signed [RSSI_W-1:0] new_str;
    logic                     room;
    logic                     out_free;
    logic                     s_acc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign room      = held_reg < CNT_W'(MAX_STATIONS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_en_reg    <= 1'b0;
            filt_bssid_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FILTER_ENABLE: filt_en_reg    <= cfg_data[0];
                CFG_FILTER_BSSID:  filt_bssid_reg <= cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            is_data_reg <= s_is_data_packet;
            len_reg     <= s_frame_length;
            fc_reg      <= s_frame_control;
            a1_reg      <= s_address_one;
            a2_reg      <= s_address_two;
            a3_reg      <= s_address_three;
            rssi_reg    <= s_signal_strength;
        end
    end

    always_comb begin
        to_ds        = fc_reg[FC_TO_DS];
        from_ds      = fc_reg[FC_FROM_DS];
        ignore_frame = !is_data_reg || (len_reg < MIN_FRAME_LEN)
                       || (fc_reg[FC_TYPE_LO+1:FC_TYPE_LO] != FTYPE_DATA)
                       || (to_ds && from_ds);
        if (to_ds) begin
            bssid = a1_reg;
            sta   = a2_reg;
        end else if (from_ds) begin
            bssid = a2_reg;
            sta   = a1_reg;
        end else begin
            bssid = a3_reg;
            sta   = a2_reg;
        end
        filtered  = filt_en_reg && (bssid != filt_bssid_reg);
        bad_sta   = sta[GROUP_BIT] || (sta == '0);
        sta_is_ap = (sta == bssid);
        early     = ignore_frame || filtered || bad_sta || sta_is_ap;
        if (ignore_frame) begin
            early_outcome = OUT_IGNORED;
        end else if (filtered) begin
            early_outcome = OUT_FILTERED;
        end else if (bad_sta) begin
            early_outcome = OUT_BAD_STA;
        end else begin
            early_outcome = OUT_STA_IS_AP;
        end
    end

    // (old*7 + new*3) / 10, truncated toward zero
    always_comb begin
        old_x    = SUM_W'(old_reg);
        rssi_x   = SUM_W'(rssi_reg);
        sum_calc = (old_x <<< 3) - old_x + (rssi_x <<< 1) + rssi_x;
        sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mag      = sum_abs[MAG_W-1:0];
        prod     = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(DIV10_MUL);
        quot     = prod[DIV10_SHIFT+RSSI_W-1:DIV10_SHIFT];
        new_str  = sum_reg[SUM_W-1] ? -$signed(quot) : $signed(quot);
    end

    // search chain
    assign tok[0].valid = (state_reg == ST_CLASS) && !early;
    assign tok[0].found = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_str[0]   = '0;
    assign tail         = tok[MAX_STATIONS];

    always_comb begin
        wr     = '0;
        wr_idx = hit_idx_reg;
        wr_str = new_str;
        if (state_reg == ST_SCAN && tail.valid && !tail.found && room) begin
            wr.en     = 1'b1;
            wr.mac_en = 1'b1;
            wr_idx    = held_reg[IDX_W-1:0];
            wr_str    = rssi_reg;
        end else if (state_reg == ST_DIV) begin
            wr.en = 1'b1;
        end
    end

    // probe is taken from the captured header, stable from ST_CLASS on
    for (genvar g = 0; g < MAX_STATIONS; g++) begin : g_cell
        wst_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .held      (held_reg),
            .probe_mac (sta),
            .tok_i     (tok[g]),
            .tok_idx_i (tok_idx[g]),
            .tok_str_i (tok_str[g]),
            .tok_o     (tok[g+1]),
            .tok_idx_o (tok_idx[g+1]),
            .tok_str_o (tok_str[g+1]),
            .wr        (wr),
            .wr_idx    (wr_idx),
            .wr_mac    (sta_reg),
            .wr_str    (wr_str)
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_acc) state_next = ST_CLASS;
            ST_CLASS: state_next = early ? ST_DONE : ST_SCAN;
            ST_SCAN: begin
                if (tail.valid) begin
                    state_next = tail.found ? ST_SUM : ST_DONE;
                end
            end
            ST_SUM:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (wr.en && wr.mac_en) begin
                held_reg <= held_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_CLASS: begin
                sta_reg         <= sta;
                res_outcome_reg <= early_outcome;
                res_idx_reg     <= '0;
                res_sta_reg     <= ignore_frame ? '0 : sta;
                res_str_reg     <= '0;
                res_chg_reg     <= 1'b0;
            end
            ST_SCAN: begin
                if (tail.valid) begin
                    hit_idx_reg <= tok_idx[MAX_STATIONS];
                    old_reg     <= tok_str[MAX_STATIONS];
                    if (!tail.found) begin
                        if (room) begin
                            res_outcome_reg <= OUT_INSERTED;
                            res_idx_reg     <= ENTRY_W'(held_reg);
                            res_str_reg     <= rssi_reg;
                            res_chg_reg     <= 1'b1;
                        end else begin
                            res_outcome_reg <= OUT_TABLE_FULL;
                        end
                    end
                end
            end
            ST_SUM: sum_reg <= sum_calc;
            ST_DIV: begin
                res_outcome_reg <= OUT_UPDATED;
                res_idx_reg     <= ENTRY_W'(hit_idx_reg);
                res_str_reg     <= new_str;
                res_chg_reg     <= (new_str != old_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_outcome_reg <= res_outcome_reg;
            m_idx_reg     <= res_idx_reg;
            m_sta_reg     <= res_sta_reg;
            m_str_reg     <= res_str_reg;
            m_chg_reg     <= res_chg_reg;
            m_count_reg   <= COUNT_W'(held_reg);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_outcome           = m_outcome_reg;
    assign m_entry_index       = m_idx_reg;
    assign m_station_address   = m_sta_reg;
    assign m_smoothed_strength = m_str_reg;
    assign m_table_changed     = m_chg_reg;
    assign m_station_count     = m_count_reg;

    `WST_ASSERT(a_held_bound, held_reg <= CNT_W'(MAX_STATIONS))
    `WST_ASSERT_IMP(a_tail_in_scan, tail.valid, state_reg == ST_SCAN)
    `WST_ASSERT_IMP(a_wr_state, wr.en, state_reg == ST_SCAN || state_reg == ST_DIV)
    `WST_ASSERT_NXT(a_insert_count, wr.en && wr.mac_en, held_reg == $past(held_reg) + CNT_W'(1))

endmodule
